FILE: rtl/core/bcs_pkg.sv
`timescale 1ns / 1ps

package bcs_pkg;

	localparam int IN_BYTES  = 15;
	localparam int OUT_BYTES = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OV_MV     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UV_MV     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OT_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UT_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PRECHG_MS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CHG_LIM   = 3'd6;

	// register reset values
	localparam logic [15:0] RST_OV_MV     = 16'd4200;
	localparam logic [15:0] RST_UV_MV     = 16'd2500;
	localparam logic [15:0] RST_OC_LIMIT  = 16'd2000;
	localparam logic [15:0] RST_OT_LIMIT  = 16'd600;
	localparam logic [15:0] RST_UT_LIMIT  = 16'd0;
	localparam logic [15:0] RST_PRECHG_MS = 16'd5000;
	localparam logic [15:0] RST_CHG_LIM   = 16'd4190;

	// sequencer states, also the mode field of a result
	localparam logic [2:0] MODE_SHUTDOWN  = 3'd0;
	localparam logic [2:0] MODE_PRECHARGE = 3'd1;
	localparam logic [2:0] MODE_ACTIVE    = 3'd2;
	localparam logic [2:0] MODE_CHARGING  = 3'd3;
	localparam logic [2:0] MODE_FAULT     = 3'd4;

	localparam logic [1:0] CMD_NONE     = 2'd0;
	localparam logic [1:0] CMD_CLOSE    = 2'd1;
	localparam logic [1:0] CMD_SHUTDOWN = 2'd2;
	localparam logic [1:0] CMD_CLEAR    = 2'd3;

	localparam int FLAG_OV   = 0;
	localparam int FLAG_UV   = 1;
	localparam int FLAG_OC   = 2;
	localparam int FLAG_OT   = 3;
	localparam int FLAG_UT   = 4;
	localparam int FLAG_OPEN = 5;
	localparam int FLAG_KILL = 6;

	typedef struct packed {
		logic [15:0] cell_overvoltage_mv;
		logic [15:0] cell_undervoltage_mv;
		logic [15:0] overcurrent_limit;
		logic [15:0] overtemp_limit;
		logic [15:0] undertemp_limit;
		logic [15:0] precharge_time_ms;
		logic [15:0] charge_voltage_limit_mv;
	} cfg_t;

	typedef struct packed {
		logic [15:0] max_cell_mv;
		logic [15:0] min_cell_mv;
		logic [15:0] pack_current;
		logic [15:0] max_temp;
		logic [15:0] min_temp;
		logic        open_wire;
		logic        kill_active;
		logic        charger_present;
		logic [1:0]  command;
		logic [31:0] now_ms;
	} tick_t;

	typedef struct packed {
		logic [6:0] flags;
		logic       above_charge_limit;
	} check_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       negative_contactor;
		logic       positive_contactor;
		logic       precharge_relay;
		logic       charger_enable;
		logic       charge_pause;
		logic [6:0] fault_flags;
		logic       any_fault;
	} result_t;

endpackage

FILE: rtl/core/bcs_cfg_regs.sv
`timescale 1ns / 1ps

module bcs_cfg_regs import bcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_overvoltage_mv     <= RST_OV_MV;
			cfg_q.cell_undervoltage_mv    <= RST_UV_MV;
			cfg_q.overcurrent_limit       <= RST_OC_LIMIT;
			cfg_q.overtemp_limit          <= RST_OT_LIMIT;
			cfg_q.undertemp_limit         <= RST_UT_LIMIT;
			cfg_q.precharge_time_ms       <= RST_PRECHG_MS;
			cfg_q.charge_voltage_limit_mv <= RST_CHG_LIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OV_MV:     cfg_q.cell_overvoltage_mv     <= cfg_data;
				CFG_UV_MV:     cfg_q.cell_undervoltage_mv    <= cfg_data;
				CFG_OC_LIMIT:  cfg_q.overcurrent_limit       <= cfg_data;
				CFG_OT_LIMIT:  cfg_q.overtemp_limit          <= cfg_data;
				CFG_UT_LIMIT:  cfg_q.undertemp_limit         <= cfg_data;
				CFG_PRECHG_MS: cfg_q.precharge_time_ms       <= cfg_data;
				CFG_CHG_LIM:   cfg_q.charge_voltage_limit_mv <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bcs_fault_check.sv
`timescale 1ns / 1ps

module bcs_fault_check import bcs_pkg::*; (
	input  cfg_t   cfg,
	input  tick_t  tick,
	output check_t chk
);

	always_comb begin
		chk.flags[FLAG_OV]   = tick.max_cell_mv >= cfg.cell_overvoltage_mv;
		chk.flags[FLAG_UV]   = tick.min_cell_mv <= cfg.cell_undervoltage_mv;
		chk.flags[FLAG_OC]   = $signed(tick.pack_current) >= $signed(cfg.overcurrent_limit);
		chk.flags[FLAG_OT]   = $signed(tick.max_temp) >= $signed(cfg.overtemp_limit);
		chk.flags[FLAG_UT]   = $signed(tick.min_temp) <= $signed(cfg.undertemp_limit);
		chk.flags[FLAG_OPEN] = tick.open_wire;
		chk.flags[FLAG_KILL] = tick.kill_active;
		chk.above_charge_limit = tick.max_cell_mv > cfg.charge_voltage_limit_mv;
	end

endmodule

FILE: rtl/core/bcs_seq.sv
`timescale 1ns / 1ps

module bcs_seq import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  tick_t       tick,
	input  check_t      chk,
	input  logic [15:0] precharge_time_ms,
	output result_t     res
);

	logic [2:0]  mode_q;
	logic        fault_pending_q;
	logic [31:0] entry_q;

	logic [2:0]  mode_cur;
	logic        forced;
	logic [2:0]  mode_a;
	logic [31:0] entry_a;
	logic [31:0] elapsed;
	logic        expired;
	logic [2:0]  mode_n;
	logic        any;
	logic        kill_clr;
	logic        charging;

	always_comb begin
		// unused codes behave as shutdown
		mode_cur = (mode_q > MODE_FAULT) ? MODE_SHUTDOWN : mode_q;
		forced   = fault_pending_q && (mode_cur != MODE_FAULT);
		mode_a   = forced ? MODE_FAULT : mode_cur;
		entry_a  = forced ? tick.now_ms : entry_q;
		elapsed  = tick.now_ms - entry_a;
		expired  = elapsed >= {16'd0, precharge_time_ms};
		any      = (|chk.flags[FLAG_UT:FLAG_OV]) || tick.open_wire ||
		           (tick.kill_active && (mode_a != MODE_SHUTDOWN));

		mode_n   = mode_a;
		kill_clr = 1'b0;
		unique case (mode_a)
			MODE_PRECHARGE: begin
				if (tick.command == CMD_SHUTDOWN) begin
					mode_n = MODE_SHUTDOWN;
				end else if (expired) begin
					if (tick.charger_present)
						mode_n = MODE_CHARGING;
					else if (tick.command == CMD_CLOSE)
						mode_n = MODE_ACTIVE;
					else
						mode_n = MODE_SHUTDOWN;
				end
			end
			MODE_ACTIVE: begin
				if (tick.command == CMD_SHUTDOWN)
					mode_n = MODE_SHUTDOWN;
				else if (tick.charger_present)
					mode_n = MODE_CHARGING;
			end
			MODE_CHARGING: begin
				if (!tick.charger_present || tick.command == CMD_SHUTDOWN)
					mode_n = MODE_SHUTDOWN;
			end
			MODE_FAULT: begin
				if (tick.command == CMD_CLEAR) begin
					mode_n   = MODE_SHUTDOWN;
					kill_clr = 1'b1;
				end
			end
			default: begin
				if (tick.command == CMD_CLOSE ||
				    (tick.charger_present && tick.command != CMD_SHUTDOWN))
					mode_n = MODE_PRECHARGE;
			end
		endcase

		charging                = mode_n == MODE_CHARGING;
		res.mode                = mode_n;
		res.negative_contactor  = (mode_n == MODE_PRECHARGE) || (mode_n == MODE_ACTIVE) ||
		                          charging;
		res.positive_contactor  = (mode_n == MODE_ACTIVE) || charging;
		res.precharge_relay     = mode_n == MODE_PRECHARGE;
		res.charger_enable      = charging;
		res.charge_pause        = charging && chk.above_charge_limit;
		res.fault_flags         = {chk.flags[FLAG_KILL] & ~kill_clr, chk.flags[FLAG_OPEN:FLAG_OV]};
		res.any_fault           = any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_SHUTDOWN;
			fault_pending_q <= 1'b0;
			entry_q         <= '0;
		end else if (advance) begin
			mode_q          <= mode_n;
			fault_pending_q <= any;
			// every state change, forced fault entry included, restarts the timer
			if (forced || (mode_n != mode_a))
				entry_q <= tick.now_ms;
		end
	end

`ifndef ASSERT_OFF
	a_pending_tracks_any: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> fault_pending_q == $past(any))
		else $error("fault_pending does not follow the combined fault");

	a_pending_forces_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fault_pending_q) |->
		(mode_n == MODE_FAULT || (mode_n == MODE_SHUTDOWN && tick.command == CMD_CLEAR)))
		else $error("latched fault did not force the fault state");

	a_entry_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_n != mode_cur) |=> entry_q == $past(tick.now_ms))
		else $error("timer not restarted on state change");

	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.precharge_relay && res.positive_contactor) &&
		(!res.positive_contactor || res.negative_contactor))
		else $error("contactor combination not allowed");
`endif

endmodule

FILE: rtl/core/battery_contactor_sequencer.sv
`timescale 1ns / 1ps

// Contactor and precharge sequencer for a battery pack. Each input word is one
// monitoring tick and gives exactly one result word. A word is held in an input
// register, then the threshold compares and the five-state sequencer update run
// combinationally into the output register, and one word can be accepted every
// cycle; the only limit is the output register, which holds its word while
// m_tready is low. Limits are to be written through the cfg port while no tick
// is in flight; the block itself does not enforce this.
module battery_contactor_sequencer import bcs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// max_cell_mv[15:0], min_cell_mv[31:16], pack_current[47:32], max_temp[63:48],
	// min_temp[79:64], open_wire[80], kill_active[81], charger_present[82],
	// command[84:83], now_ms[116:85], zero fill[119:117]
	input  logic [IN_BYTES*8-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// mode[2:0], negative_contactor[3], positive_contactor[4], precharge_relay[5],
	// charger_enable[6], charge_pause[7], fault_flags[14:8], any_fault[15]
	output logic [OUT_BYTES*8-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	check_t  chk;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.max_cell_mv     <= s_tdata[15:0];
			tick_s1.min_cell_mv     <= s_tdata[31:16];
			tick_s1.pack_current    <= s_tdata[47:32];
			tick_s1.max_temp        <= s_tdata[63:48];
			tick_s1.min_temp        <= s_tdata[79:64];
			tick_s1.open_wire       <= s_tdata[80];
			tick_s1.kill_active     <= s_tdata[81];
			tick_s1.charger_present <= s_tdata[82];
			tick_s1.command         <= s_tdata[84:83];
			tick_s1.now_ms          <= s_tdata[116:85];
		end
		if (advance)
			res_s2 <= res;
	end

	bcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcs_fault_check u_check (
		.cfg  (cfg),
		.tick (tick_s1),
		.chk  (chk)
	);

	bcs_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.tick              (tick_s1),
		.chk               (chk),
		.precharge_time_ms (cfg.precharge_time_ms),
		.res               (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.any_fault, res_s2.fault_flags, res_s2.charge_pause,
	                   res_s2.charger_enable, res_s2.precharge_relay,
	                   res_s2.positive_contactor, res_s2.negative_contactor, res_s2.mode};

endmodule

FILE: bench/battery_contactor_sequencer_test.sv
`timescale 1ns / 1ps

module battery_contactor_sequencer_test;
	import bcs_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic [IN_BYTES*8-1:0]  s_tdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [OUT_BYTES*8-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	battery_contactor_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer model state and its copy of the limits
	logic [2:0]         seq_mode;
	logic               fault_latched;
	logic [31:0]        state_entry_ms;
	logic [15:0]        lim_ov, lim_uv, lim_prechg, lim_chg;
	logic signed [15:0] lim_oc, lim_ot, lim_ut;

	result_t predicted_results[$];
	int      error_count;
	int      mismatch_count;

	bit          src_idle_on;
	bit          sink_idle_on;
	int          holdoff_req;
	logic [31:0] sim_now;
	logic        charger_plugged;

	function automatic void enter_state(input logic [2:0] next, input logic [31:0] now);
		seq_mode       = next;
		state_entry_ms = now;
	endfunction

	function automatic result_t predict_tick(input tick_t t);
		result_t     r;
		logic [6:0]  flags;
		logic        any;
		logic [31:0] elapsed;
		if (seq_mode > MODE_FAULT)
			seq_mode = MODE_SHUTDOWN;
		if (fault_latched && seq_mode != MODE_FAULT)
			enter_state(MODE_FAULT, t.now_ms);
		flags = '0;
		flags[FLAG_OV]   = t.max_cell_mv >= lim_ov;
		flags[FLAG_UV]   = t.min_cell_mv <= lim_uv;
		flags[FLAG_OC]   = $signed(t.pack_current) >= lim_oc;
		flags[FLAG_OT]   = $signed(t.max_temp) >= lim_ot;
		flags[FLAG_UT]   = $signed(t.min_temp) <= lim_ut;
		flags[FLAG_OPEN] = t.open_wire;
		flags[FLAG_KILL] = t.kill_active;
		// kill counts only once out of shutdown (after the forced fault entry)
		any = (|flags[FLAG_UT:FLAG_OV]) || t.open_wire ||
			(t.kill_active && seq_mode != MODE_SHUTDOWN);
		fault_latched = any;
		elapsed = t.now_ms - state_entry_ms;
		case (seq_mode)
			MODE_PRECHARGE: begin
				if (t.command == CMD_SHUTDOWN)
					enter_state(MODE_SHUTDOWN, t.now_ms);
				else if (elapsed >= {16'd0, lim_prechg}) begin
					if (t.charger_present)
						enter_state(MODE_CHARGING, t.now_ms);
					else if (t.command == CMD_CLOSE)
						enter_state(MODE_ACTIVE, t.now_ms);
					else
						enter_state(MODE_SHUTDOWN, t.now_ms);
				end
			end
			MODE_ACTIVE: begin
				if (t.command == CMD_SHUTDOWN)
					enter_state(MODE_SHUTDOWN, t.now_ms);
				else if (t.charger_present)
					enter_state(MODE_CHARGING, t.now_ms);
			end
			MODE_CHARGING: begin
				if (!t.charger_present || t.command == CMD_SHUTDOWN)
					enter_state(MODE_SHUTDOWN, t.now_ms);
			end
			MODE_FAULT: begin
				if (t.command == CMD_CLEAR) begin
					flags[FLAG_KILL] = 1'b0;
					enter_state(MODE_SHUTDOWN, t.now_ms);
				end
			end
			default: begin
				if (t.command == CMD_CLOSE || (t.charger_present && t.command != CMD_SHUTDOWN))
					enter_state(MODE_PRECHARGE, t.now_ms);
			end
		endcase
		r.mode               = seq_mode;
		r.negative_contactor = seq_mode == MODE_PRECHARGE || seq_mode == MODE_ACTIVE ||
			seq_mode == MODE_CHARGING;
		r.positive_contactor = seq_mode == MODE_ACTIVE || seq_mode == MODE_CHARGING;
		r.precharge_relay    = seq_mode == MODE_PRECHARGE;
		r.charger_enable     = seq_mode == MODE_CHARGING;
		r.charge_pause       = seq_mode == MODE_CHARGING && t.max_cell_mv > lim_chg;
		r.fault_flags        = flags;
		r.any_fault          = any;
		return r;
	endfunction

	function automatic logic [IN_BYTES*8-1:0] pack_tick(input tick_t t);
		return {3'b000, t.now_ms, t.command, t.charger_present, t.kill_active, t.open_wire,
			t.min_temp, t.max_temp, t.pack_current, t.min_cell_mv, t.max_cell_mv};
	endfunction

	function automatic tick_t nominal_tick(input logic [31:0] now, input logic [1:0] cmd,
		input logic charger);
		tick_t t;
		t.max_cell_mv     = 16'd3700;
		t.min_cell_mv     = 16'd3500;
		t.pack_current    = 16'd100;
		t.max_temp        = 16'd250;
		t.min_temp        = 16'd200;
		t.open_wire       = 1'b0;
		t.kill_active     = 1'b0;
		t.charger_present = charger;
		t.command         = cmd;
		t.now_ms          = now;
		return t;
	endfunction

	// Mostly plausible pack readings with an advancing clock; fault_pct pushes one
	// reading out of range, noise_pct gives a word with every field random.
	function automatic tick_t random_tick(input int fault_pct, input int noise_pct);
		tick_t t;
		int    roll;
		if ($urandom_range(99) < noise_pct) begin
			t.max_cell_mv     = 16'($urandom);
			t.min_cell_mv     = 16'($urandom);
			t.pack_current    = 16'($urandom);
			t.max_temp        = 16'($urandom);
			t.min_temp        = 16'($urandom);
			t.open_wire       = 1'($urandom);
			t.kill_active     = 1'($urandom);
			t.charger_present = 1'($urandom);
			t.command         = 2'($urandom);
			t.now_ms          = $urandom;
			sim_now           = t.now_ms;
			return t;
		end
		if ($urandom_range(99) < 4)
			charger_plugged = !charger_plugged;
		t.max_cell_mv     = 16'($urandom_range(3000, 4199));
		t.min_cell_mv     = 16'($urandom_range(2501, 3600));
		t.pack_current    = 16'(int'($urandom_range(0, 3999)) - 2000);
		t.max_temp        = 16'($urandom_range(1, 599));
		t.min_temp        = 16'($urandom_range(1, 599));
		t.open_wire       = $urandom_range(99) < 1;
		t.kill_active     = $urandom_range(99) < 2;
		t.charger_present = charger_plugged;
		roll = $urandom_range(99);
		if (roll < 45)
			t.command = CMD_NONE;
		else if (roll < 75)
			t.command = CMD_CLOSE;
		else if (roll < 87)
			t.command = CMD_SHUTDOWN;
		else
			t.command = CMD_CLEAR;
		if ($urandom_range(99) < fault_pct) begin
			case ($urandom_range(0, 6))
				0: t.max_cell_mv  = 16'($urandom_range(4200, 65535));
				1: t.min_cell_mv  = 16'($urandom_range(0, 2500));
				2: t.pack_current = 16'($urandom_range(2000, 32767));
				3: t.max_temp     = 16'($urandom_range(600, 32767));
				4: t.min_temp     = 16'(-int'($urandom_range(0, 32768)));
				5: t.open_wire    = 1'b1;
				default: t.kill_active = 1'b1;
			endcase
		end
		// step so that precharge lasts a few ticks whatever its length
		if ($urandom_range(99) < 3)
			sim_now = $urandom;
		else
			sim_now = sim_now + $urandom_range(1, int'(lim_prechg) / 2 + 1);
		t.now_ms = sim_now;
		return t;
	endfunction

	// Leaves s_tvalid high at the accepting edge; the next call or a drain owns it.
	task automatic send_tick(input tick_t t);
		while (src_idle_on && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_tick(t);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted_results.push_back(predict_tick(t));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_OV_MV:     lim_ov     = value;
			CFG_UV_MV:     lim_uv     = value;
			CFG_OC_LIMIT:  lim_oc     = value;
			CFG_OT_LIMIT:  lim_ot     = value;
			CFG_UT_LIMIT:  lim_ut     = value;
			CFG_PRECHG_MS: lim_prechg = value;
			CFG_CHG_LIM:   lim_chg    = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_limits(input logic [15:0] ov, input logic [15:0] uv,
		input logic [15:0] oc, input logic [15:0] ot, input logic [15:0] ut,
		input logic [15:0] prechg, input logic [15:0] chg);
		drain_results();
		write_limit(CFG_OV_MV, ov);
		write_limit(CFG_UV_MV, uv);
		write_limit(CFG_OC_LIMIT, oc);
		write_limit(CFG_OT_LIMIT, ot);
		write_limit(CFG_UT_LIMIT, ut);
		write_limit(CFG_PRECHG_MS, prechg);
		write_limit(CFG_CHG_LIM, chg);
	endtask

	task automatic run_random(input int count, input int fault_pct, input int noise_pct);
		repeat (count) send_tick(random_tick(fault_pct, noise_pct));
	endtask

	// reset limits, timer expiry paths, wrap, fault entry and clear, field extremes
	task automatic test_directed();
		tick_t t;
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_tick(nominal_tick(32'd10, CMD_NONE, 1'b0));
		t = nominal_tick(32'd20, CMD_NONE, 1'b0);
		t.kill_active = 1'b1;
		send_tick(t);
		send_tick(nominal_tick(32'd100, CMD_CLOSE, 1'b0));
		send_tick(nominal_tick(32'd4000, CMD_NONE, 1'b0));
		send_tick(nominal_tick(32'd5100, CMD_NONE, 1'b0));
		send_tick(nominal_tick(32'd5200, CMD_CLOSE, 1'b0));
		send_tick(nominal_tick(32'd10200, CMD_CLOSE, 1'b0));
		t = nominal_tick(32'd10300, CMD_NONE, 1'b1);
		t.max_cell_mv = 16'd4195;
		send_tick(t);
		send_tick(nominal_tick(32'd10400, CMD_NONE, 1'b0));
		send_tick(nominal_tick(32'd10500, CMD_NONE, 1'b1));
		send_tick(nominal_tick(32'd15500, CMD_NONE, 1'b1));
		send_tick(nominal_tick(32'd15600, CMD_SHUTDOWN, 1'b1));
		send_tick(nominal_tick(32'd15700, CMD_CLOSE, 1'b0));
		// shutdown wins over an expired timer
		send_tick(nominal_tick(32'd30000, CMD_SHUTDOWN, 1'b1));
		// precharge across the timestamp wrap
		send_tick(nominal_tick(32'hFFFF_FF00, CMD_CLOSE, 1'b0));
		send_tick(nominal_tick(32'h0000_1000, CMD_NONE, 1'b0));
		send_tick(nominal_tick(32'h0000_1400, CMD_CLOSE, 1'b0));
		t = nominal_tick(32'h0000_2000, CMD_NONE, 1'b0);
		t.kill_active = 1'b1;
		send_tick(t);
		send_tick(nominal_tick(32'h0000_2100, CMD_NONE, 1'b0));
		t = nominal_tick(32'h0000_2200, CMD_CLEAR, 1'b0);
		t.kill_active = 1'b1;
		send_tick(t);
		t = nominal_tick(32'h0000_2300, CMD_NONE, 1'b0);
		t.max_cell_mv  = 16'hFFFF;
		t.min_cell_mv  = 16'h0000;
		t.pack_current = 16'h7FFF;
		t.max_temp     = 16'h7FFF;
		t.min_temp     = 16'h8000;
		t.open_wire    = 1'b1;
		send_tick(t);
		// forced fault and clear on one tick
		send_tick(nominal_tick(32'h0000_2400, CMD_CLEAR, 1'b0));
		t = nominal_tick(32'h0000_2500, CMD_NONE, 1'b0);
		t.max_cell_mv  = 16'h0000;
		t.min_cell_mv  = 16'hFFFF;
		t.pack_current = 16'h8000;
		t.max_temp     = 16'h8000;
		t.min_temp     = 16'h7FFF;
		send_tick(t);
		send_tick(nominal_tick(32'h0000_2600, CMD_CLEAR, 1'b0));
	endtask

	task automatic test_sequences();
		sim_now = 32'd1000;
		load_limits(16'd4200, 16'd2500, 16'd2000, 16'd600, 16'd0,
			16'($urandom_range(20, 200)), 16'd4100);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		run_random(200, 4, 4);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		run_random(250, 6, 6);
		// sender stops until everything is back, then goes on with a new timer
		load_limits(16'd4200, 16'd2500, 16'd2000, 16'd600, 16'd0,
			16'($urandom_range(1, 1000)), 16'd4150);
		run_random(250, 6, 6);
	endtask

	task automatic test_backpressure();
		holdoff_req = 300;
		run_random(60, 5, 5);
		drain_results();
	endtask

	task automatic test_limit_extremes();
		load_limits(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
		run_random(50, 5, 10);
		load_limits(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		run_random(50, 5, 10);
		load_limits(16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
		run_random(60, 3, 5);
	endtask

	task automatic test_random_limits();
		repeat (3) begin
			load_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			run_random(80, 10, 25);
		end
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req != 0) begin
				stall_left  = holdoff_req;
				holdoff_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= !(sink_idle_on && $urandom_range(99) < 12);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.mode               = m_tdata[2:0];
			got.negative_contactor = m_tdata[3];
			got.positive_contactor = m_tdata[4];
			got.precharge_relay    = m_tdata[5];
			got.charger_enable     = m_tdata[6];
			got.charge_pause       = m_tdata[7];
			got.fault_flags        = m_tdata[14:8];
			got.any_fault          = m_tdata[15];
			if (predicted_results.size() == 0) begin
				error_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result word with none predicted: %h", $realtime, m_tdata);
			end else begin
				want = predicted_results.pop_front();
				if (got.mode !== want.mode ||
					got.negative_contactor !== want.negative_contactor ||
					got.positive_contactor !== want.positive_contactor ||
					got.precharge_relay !== want.precharge_relay ||
					got.charger_enable !== want.charger_enable ||
					got.charge_pause !== want.charge_pause ||
					got.fault_flags !== want.fault_flags ||
					got.any_fault !== want.any_fault) begin
					error_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: mismatch mode/neg/pos/pre/chg/pause/flags/any ",
							"expected %0d %b %b %b %b %b %b %b got %0d %b %b %b %b %b %b %b"},
							$realtime, want.mode, want.negative_contactor,
							want.positive_contactor, want.precharge_relay, want.charger_enable,
							want.charge_pause, want.fault_flags, want.any_fault, got.mode,
							got.negative_contactor, got.positive_contactor, got.precharge_relay,
							got.charger_enable, got.charge_pause, got.fault_flags, got.any_fault);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("battery_contactor_sequencer_test failed");
		$finish;
	end

	initial begin
		error_count     = 0;
		mismatch_count  = 0;
		src_idle_on     = 1'b0;
		sink_idle_on    = 1'b0;
		holdoff_req     = 0;
		sim_now         = 32'd0;
		charger_plugged = 1'b0;
		seq_mode        = MODE_SHUTDOWN;
		fault_latched   = 1'b0;
		state_entry_ms  = 32'd0;
		lim_ov          = RST_OV_MV;
		lim_uv          = RST_UV_MV;
		lim_oc          = RST_OC_LIMIT;
		lim_ot          = RST_OT_LIMIT;
		lim_ut          = RST_UT_LIMIT;
		lim_prechg      = RST_PRECHG_MS;
		lim_chg         = RST_CHG_LIM;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_sequences();
		test_backpressure();
		test_limit_extremes();
		test_random_limits();
		drain_results();
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("battery_contactor_sequencer_test passed");
		else
			$display("battery_contactor_sequencer_test failed");
		$finish;
	end

endmodule
